>>> hw/rtl/fsp_pkg.sv
// Shared constants for the Fermat spiral point generator.
`default_nettype none

package fsp_pkg;

    localparam int unsigned POINT_COUNT = 1024;
    localparam int unsigned INDEX_W     = 10;
    localparam int unsigned STEP_W      = 16;
    localparam int unsigned BIGT_W      = INDEX_W + STEP_W;
    localparam int unsigned COORD_W     = 24;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_SCALE      = 1'b0,
        CFG_ANGLE_STEP = 1'b1
    } t_cfg_index;

    localparam logic [15:0] SCALE_RESET      = 16'd256;
    localparam logic [15:0] ANGLE_STEP_RESET = 16'd17157;

    // round(2^40 / (2*pi)) split into two 19-bit halves for the phase multiply.
    localparam logic [37:0] INV_TWO_PI_Q40 = 38'd174992710548;
    localparam logic [18:0] INV_TWO_PI_LO  = INV_TWO_PI_Q40[18:0];
    localparam logic [18:0] INV_TWO_PI_HI  = INV_TWO_PI_Q40[37:19];
    localparam logic [30:0] HALF_PI_Q30    = 31'd1686629713;
    localparam logic [30:0] Q30_ONE        = 31'h4000_0000;

    localparam int unsigned TRIG_ITERS  = 6;
    localparam int unsigned SQRT_STEPS  = 29;
    localparam int unsigned SQRT_STAGES = (SQRT_STEPS + 1) / 2;
    localparam int unsigned PIPE_DEPTH  = 22;

    // Horner divisors are applied as a multiply by ceil(2^k/d) and a shift by k.
    // k is chosen so that the quotient is exact for every operand below 2^30.
    localparam int unsigned K_COS [TRIG_ITERS] = '{39, 38, 37, 36, 35, 32};
    localparam int unsigned K_SIN [TRIG_ITERS] = '{39, 38, 38, 37, 36, 34};
    localparam logic [31:0] M_COS [TRIG_ITERS] = '{
        32'(((64'd1 << 39) + 64'd131) / 64'd132),
        32'(((64'd1 << 38) + 64'd89) / 64'd90),
        32'(((64'd1 << 37) + 64'd55) / 64'd56),
        32'(((64'd1 << 36) + 64'd29) / 64'd30),
        32'(((64'd1 << 35) + 64'd11) / 64'd12),
        32'(((64'd1 << 32) + 64'd1) / 64'd2)
    };
    localparam logic [31:0] M_SIN [TRIG_ITERS] = '{
        32'(((64'd1 << 39) + 64'd155) / 64'd156),
        32'(((64'd1 << 38) + 64'd109) / 64'd110),
        32'(((64'd1 << 38) + 64'd71) / 64'd72),
        32'(((64'd1 << 37) + 64'd41) / 64'd42),
        32'(((64'd1 << 36) + 64'd19) / 64'd20),
        32'(((64'd1 << 34) + 64'd5) / 64'd6)
    };

    typedef struct packed {
        logic [57:0] v;
        logic [58:0] res;
    } t_sqrt;

    // One digit of the restoring square root.
    function automatic t_sqrt sqrt_step(t_sqrt s, int unsigned step);
        logic [58:0] bit_w;
        logic [58:0] trial;
        t_sqrt       o;
        bit_w = 59'd1 << (56 - 2 * step);
        trial = s.res + bit_w;
        o     = s;
        if ({1'b0, s.v} >= trial) begin
            o.v   = 58'({1'b0, s.v} - trial);
            o.res = (s.res >> 1) + bit_w;
        end else begin
            o.res = s.res >> 1;
        end
        return o;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/fermat_spiral_point_generator.sv
// Fermat spiral point generator: index in, both spiral arms out.
// The input channel carries a point index n; each request yields one result
// with (r*cos t, r*sin t) and its mirror through the origin, signed Q15.8,
// where t = angle_step*n radians and r = scale*sqrt(t).
// The configuration port writes scale (index 0) and angle_step (index 1);
// writes take effect at once; the user must make them only while no request
// is in flight; the block does not enforce this. The datapath has 22 register
// stages and accepts one request in every cycle unless the output stalls.
// The depth is set by the six Horner steps of the sine and cosine, two
// stages each, with the digit-by-digit square root running beside them.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and input ready drops; nothing is lost or repeated.
// A synchronous active-low reset empties the pipeline and sets scale to 1.0
// and angle_step to about pi/12.
`default_nettype none

module fermat_spiral_point_generator
    import fsp_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [0:0]           i_cfg_index,
    input  wire logic [15:0]          i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [INDEX_W-1:0]   i_point_index,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic signed [COORD_W-1:0] o_x_pos,
    output logic signed [COORD_W-1:0] o_y_pos,
    output logic signed [COORD_W-1:0] o_x_mirror,
    output logic signed [COORD_W-1:0] o_y_mirror
);

    logic [15:0]         r_scale;
    logic [15:0]         r_angle_step;
    logic [PIPE_DEPTH-1:0] r_vld;
    logic                en;

    // Stage registers.
    logic [BIGT_W-1:0]   r1_bigt;
    logic [44:0]         r2_plo;
    logic [44:0]         r2_phi;
    logic [1:0]          r3_quad;
    logic                r3_swap;
    logic [29:0]         r3_u;
    logic [60:0]         r4_xprod;
    logic [1:0]          r4_quad;
    logic                r4_swap;
    logic [29:0]         r5_x;
    logic [1:0]          r5_quad;
    logic                r5_swap;
    logic [59:0]         r6_x2p;
    logic [29:0]         r6_x;
    logic [1:0]          r6_quad;
    logic                r6_swap;

    logic [60:0]         r_pc [TRIG_ITERS];
    logic [60:0]         r_ps [TRIG_ITERS];
    logic [61:0]         r_dc [TRIG_ITERS];
    logic [61:0]         r_ds [TRIG_ITERS];
    logic [29:0]         r_tx  [2*TRIG_ITERS];
    logic [29:0]         r_tx2 [2*TRIG_ITERS];
    logic [1:0]          r_tq  [2*TRIG_ITERS];
    logic                r_tsw [2*TRIG_ITERS];

    t_sqrt               r_sq [SQRT_STAGES];
    t_sqrt               n_sq [SQRT_STAGES];

    logic [44:0]         r17_rp;
    logic [28:0]         r18_r16;
    logic [28:0]         r19_r16;
    logic [28:0]         r20_r16;
    logic [60:0]         r19_sup;
    logic [30:0]         r19_hc;
    logic [1:0]          r19_quad;
    logic                r19_swap;
    logic [30:0]         r20_cm;
    logic [30:0]         r20_sm;
    logic                r20_cneg;
    logic                r20_sneg;
    logic [59:0]         r21_xp;
    logic [59:0]         r21_yp;
    logic                r21_cneg;
    logic                r21_sneg;

    // Combinational values between stages.
    logic [63:0]         phase_full;
    logic [31:0]         phase;
    logic [30:0]         u_wide;
    logic [61:0]         x_round;
    logic [30:0]         n_hc [TRIG_ITERS];
    logic [30:0]         n_hs [TRIG_ITERS];
    logic [29:0]         n_x2 [TRIG_ITERS];
    logic [30:0]         hc_fin;
    logic [30:0]         hs_fin;
    logic [30:0]         su;
    logic [30:0]         ct;
    logic [30:0]         st;
    logic [30:0]         n_cm;
    logic [30:0]         n_sm;
    logic                n_cneg;
    logic                n_sneg;
    logic [60:0]         xm_sum;
    logic [60:0]         ym_sum;
    logic [COORD_W-1:0]  xm;
    logic [COORD_W-1:0]  ym;
    logic [COORD_W-1:0]  x_field;
    logic [COORD_W-1:0]  y_field;

    assign en          = !r_vld[PIPE_DEPTH-1] || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_vld[PIPE_DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale      <= SCALE_RESET;
            r_angle_step <= ANGLE_STEP_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_SCALE:      r_scale      <= i_cfg_data;
                CFG_ANGLE_STEP: r_angle_step <= i_cfg_data;
                default:        r_scale      <= r_scale;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_in_valid};
        end
    end

    always_comb begin
        t_sqrt s_tmp;
        phase_full = {19'd0, r2_plo} + {r2_phi, 19'd0};
        phase      = phase_full[55:24];
        u_wide     = phase[29] ? (Q30_ONE - {1'b0, phase[29:0]}) : {1'b0, phase[29:0]};
        x_round    = {1'b0, r4_xprod} + 62'(Q30_ONE >> 1);

        for (int i = 0; i < TRIG_ITERS; i++) begin
            if (i == 0) begin
                n_hc[i] = Q30_ONE;
                n_hs[i] = Q30_ONE;
                n_x2[i] = r6_x2p[59:30];
            end else begin
                n_hc[i] = Q30_ONE - 31'(r_dc[i-1] >> K_COS[i-1]);
                n_hs[i] = Q30_ONE - 31'(r_ds[i-1] >> K_SIN[i-1]);
                n_x2[i] = r_tx2[2*i-1];
            end
        end
        hc_fin = Q30_ONE - 31'(r_dc[TRIG_ITERS-1] >> K_COS[TRIG_ITERS-1]);
        hs_fin = Q30_ONE - 31'(r_ds[TRIG_ITERS-1] >> K_SIN[TRIG_ITERS-1]);

        for (int j = 0; j < SQRT_STAGES; j++) begin
            if (j == 0) begin
                s_tmp.v   = {r1_bigt, 32'd0};
                s_tmp.res = '0;
            end else begin
                s_tmp = r_sq[j-1];
            end
            s_tmp = sqrt_step(s_tmp, 2 * j);
            if (2 * j + 1 < SQRT_STEPS) begin
                s_tmp = sqrt_step(s_tmp, 2 * j + 1);
            end
            n_sq[j] = s_tmp;
        end

        su = r19_sup[60:30];
        ct = r19_swap ? su : r19_hc;
        st = r19_swap ? r19_hc : su;
        case (r19_quad)
            2'd0: begin
                n_cm = ct; n_sm = st; n_cneg = 1'b0; n_sneg = 1'b0;
            end
            2'd1: begin
                n_cm = st; n_sm = ct; n_cneg = 1'b1; n_sneg = 1'b0;
            end
            2'd2: begin
                n_cm = ct; n_sm = st; n_cneg = 1'b1; n_sneg = 1'b1;
            end
            default: begin
                n_cm = st; n_sm = ct; n_cneg = 1'b0; n_sneg = 1'b1;
            end
        endcase

        xm_sum  = {1'b0, r21_xp} + (61'd1 << 37);
        ym_sum  = {1'b0, r21_yp} + (61'd1 << 37);
        xm      = COORD_W'(xm_sum >> 38);
        ym      = COORD_W'(ym_sum >> 38);
        // A zero magnitude stays zero under negation, so no sign fix-up is needed.
        x_field = r21_cneg ? (COORD_W'(0) - xm) : xm;
        y_field = r21_sneg ? (COORD_W'(0) - ym) : ym;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_bigt  <= BIGT_W'(r_angle_step) * BIGT_W'(i_point_index);
            r2_plo   <= 45'(r1_bigt) * 45'(INV_TWO_PI_LO);
            r2_phi   <= 45'(r1_bigt) * 45'(INV_TWO_PI_HI);
            r3_quad  <= phase[31:30];
            r3_swap  <= phase[29];
            r3_u     <= u_wide[29:0];
            r4_xprod <= 61'(r3_u) * 61'(HALF_PI_Q30);
            r4_quad  <= r3_quad;
            r4_swap  <= r3_swap;
            r5_x     <= x_round[59:30];
            r5_quad  <= r4_quad;
            r5_swap  <= r4_swap;
            r6_x2p   <= 60'(r5_x) * 60'(r5_x);
            r6_x     <= r5_x;
            r6_quad  <= r5_quad;
            r6_swap  <= r5_swap;

            // Each Horner step: multiply by x^2, then divide by its constant.
            for (int i = 0; i < TRIG_ITERS; i++) begin
                r_pc[i] <= 61'(n_x2[i]) * 61'(n_hc[i]);
                r_ps[i] <= 61'(n_x2[i]) * 61'(n_hs[i]);
                r_dc[i] <= 62'(r_pc[i][59:30]) * 62'(M_COS[i]);
                r_ds[i] <= 62'(r_ps[i][59:30]) * 62'(M_SIN[i]);
            end
            for (int t = 0; t < 2 * TRIG_ITERS; t++) begin
                if (t == 0) begin
                    r_tx[t]  <= r6_x;
                    r_tx2[t] <= r6_x2p[59:30];
                    r_tq[t]  <= r6_quad;
                    r_tsw[t] <= r6_swap;
                end else begin
                    r_tx[t]  <= r_tx[t-1];
                    r_tx2[t] <= r_tx2[t-1];
                    r_tq[t]  <= r_tq[t-1];
                    r_tsw[t] <= r_tsw[t-1];
                end
            end

            for (int j = 0; j < SQRT_STAGES; j++) begin
                r_sq[j] <= n_sq[j];
            end
            r17_rp  <= 45'(r_scale) * 45'(r_sq[SQRT_STAGES-1].res[28:0]);
            r18_r16 <= 29'((46'(r17_rp) + 46'd32768) >> 16);
            r19_r16 <= r18_r16;
            r20_r16 <= r19_r16;

            r19_sup  <= 61'(r_tx[2*TRIG_ITERS-1]) * 61'(hs_fin);
            r19_hc   <= hc_fin;
            r19_quad <= r_tq[2*TRIG_ITERS-1];
            r19_swap <= r_tsw[2*TRIG_ITERS-1];

            r20_cm   <= n_cm;
            r20_sm   <= n_sm;
            r20_cneg <= n_cneg;
            r20_sneg <= n_sneg;

            r21_xp   <= 60'(r20_r16) * 60'(r20_cm);
            r21_yp   <= 60'(r20_r16) * 60'(r20_sm);
            r21_cneg <= r20_cneg;
            r21_sneg <= r20_sneg;

            o_x_pos    <= x_field;
            o_y_pos    <= y_field;
            o_x_mirror <= COORD_W'(0) - x_field;
            o_y_mirror <= COORD_W'(0) - y_field;
        end
    end

endmodule

`default_nettype wire
